/* rtl/rth_pkg.sv */
// rth_pkg: shared widths, item and result types for the rgb_to_hsv block
// no dependencies; imported by every module of the block

package rth_pkg;

	localparam int CH_W       = 8;
	localparam int T_W        = 11;
	localparam int HUE_W      = 15;
	localparam int SAT_W      = 8;
	localparam int SXW        = 16;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// hue numerator in sixths of the circle, delta and max channel
	typedef struct packed {
		logic [T_W-1:0]  t;
		logic [CH_W-1:0] delta;
		logic [CH_W-1:0] maxc;
	} rth_item_t;

	// packed so that hue sits in the lowest bits
	typedef struct packed {
		logic [CH_W-1:0]  brightness;
		logic [SAT_W-1:0] saturation;
		logic [HUE_W-1:0] hue;
	} rth_result_t;

endpackage

/* rtl/rth_front.sv */
// rth_front: input register, max/min/delta and hue sector classification
// depends on rth_pkg

module rth_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [rth_pkg::IN_W-1:0] s_axis_tdata, // red, green, blue
	output logic                    item_valid,
	input  logic                    item_ready,
	output rth_pkg::rth_item_t      item
);
	import rth_pkg::*;

	logic [CH_W-1:0] r, g, b, mx, mn, d;
	logic [T_W-1:0]  t;
	rth_item_t       item_nxt;
	rth_item_t       item_s1;
	logic            valid_s1;

	assign r = s_axis_tdata[CH_W-1:0];
	assign g = s_axis_tdata[2*CH_W-1:CH_W];
	assign b = s_axis_tdata[3*CH_W-1:2*CH_W];

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		// blue wins ties over green, green over red
		priority if (mx == b) begin
			t = T_W'(r) + (T_W'(d) << 2) - T_W'(g);
		end else if (mx == g) begin
			t = T_W'(b) + (T_W'(d) << 1) - T_W'(r);
		end else if (g >= b) begin
			t = T_W'(g) - T_W'(b);
		end else begin
			t = (T_W'(d) << 2) + (T_W'(d) << 1) + T_W'(g) - T_W'(b);
		end
		item_nxt.t     = t;
		item_nxt.delta = d;
		item_nxt.maxc  = mx;
	end

	assign s_axis_tready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_nxt;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_ready) |=> (valid_s1 && $stable(item_s1)))
		else $error("front item changed while waiting for the queue");

endmodule

/* rtl/rth_fifo.sv */
// rth_fifo: short queue of classified items between front and back
// depends on rth_pkg

module rth_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rth_pkg::rth_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rth_pkg::rth_item_t out_item
);
	import rth_pkg::*;

	rth_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 push, pop;

	assign in_ready  = count_q != FIFO_CW'(FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	a_fifo_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count lost an item");

endmodule

/* rtl/rth_back.sv */
// rth_back: pipelined restoring dividers for hue and saturation, output register
// depends on rth_pkg

module rth_back #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  rth_pkg::rth_item_t   item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output rth_pkg::rth_result_t res
);
	import rth_pkg::*;

	localparam int SIXTH = 60 << HUE_FRAC_BITS;
	localparam int FULL  = 6 * SIXTH;
	localparam int QH    = $clog2(FULL + 1);
	localparam int HW    = QH + CH_W;
	localparam logic [HW-1:0] SIXTH_V = HW'(SIXTH);

	logic              en;
	logic              valid_s [QH+1];
	logic [HW-1:0]     hrem_s  [QH+1];
	logic [CH_W-1:0]   hden_s  [QH+1];
	logic [QH-1:0]     hq_s    [QH+1];
	logic [SXW-1:0]    srem_s  [QH+1];
	logic [CH_W-1:0]   sden_s  [QH+1];
	logic [SAT_W-1:0]  sq_s    [QH+1];
	logic              gray_s  [QH+1];
	logic [CH_W-1:0]   maxc_s  [QH+1];
	logic              out_valid_q;
	rth_result_t       res_q;
	logic [HUE_W-1:0]  hue_fin;
	logic [SAT_W-1:0]  sat_fin;

	assign en         = !out_valid_q || res_ready;
	assign item_ready = en;

	// rounded divisions: hue = (num + d/2) div d, sat = (255*d + max/2) div max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_valid) begin
			hrem_s[0] <= SIXTH_V * HW'(item.t) + HW'(item.delta >> 1);
			hden_s[0] <= item.delta;
			hq_s[0]   <= '0;
			srem_s[0] <= (SXW'(item.delta) << 8) - SXW'(item.delta)
			             + SXW'(item.maxc >> 1);
			sden_s[0] <= item.maxc;
			sq_s[0]   <= '0;
			gray_s[0] <= item.delta == '0;
			maxc_s[0] <= item.maxc;
		end
	end

	for (genvar k = 0; k < QH; k++) begin : g_step
		logic [HW-1:0]    hsub, hrem_nxt;
		logic [QH-1:0]    hq_nxt;
		logic             hge;
		logic [SXW-1:0]   srem_nxt;
		logic [SAT_W-1:0] sq_nxt;

		always_comb begin
			hsub     = HW'(hden_s[k]) << (QH - 1 - k);
			hge      = hrem_s[k] >= hsub;
			hrem_nxt = hge ? hrem_s[k] - hsub : hrem_s[k];
			hq_nxt   = hq_s[k];
			hq_nxt[QH-1-k] = hge;
		end

		if (k < SAT_W) begin : g_sat
			logic [SXW-1:0] ssub;
			logic           sge;

			always_comb begin
				ssub     = SXW'(sden_s[k]) << (SAT_W - 1 - k);
				sge      = srem_s[k] >= ssub;
				srem_nxt = sge ? srem_s[k] - ssub : srem_s[k];
				sq_nxt   = sq_s[k];
				sq_nxt[SAT_W-1-k] = sge;
			end
		end else begin : g_pass
			assign srem_nxt = srem_s[k];
			assign sq_nxt   = sq_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s[k+1] <= hrem_nxt;
				hden_s[k+1] <= hden_s[k];
				hq_s[k+1]   <= hq_nxt;
				srem_s[k+1] <= srem_nxt;
				sden_s[k+1] <= sden_s[k];
				sq_s[k+1]   <= sq_nxt;
				gray_s[k+1] <= gray_s[k];
				maxc_s[k+1] <= maxc_s[k];
			end
		end
	end

	// full circle wraps to zero, gray pixels give zero hue and saturation
	always_comb begin
		if (gray_s[QH] || hq_s[QH] >= QH'(FULL)) begin
			hue_fin = '0;
		end else begin
			hue_fin = HUE_W'(hq_s[QH]);
		end
		sat_fin = gray_s[QH] ? '0 : sq_s[QH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s[QH];
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s[QH]) begin
			res_q.hue        <= hue_fin;
			res_q.saturation <= sat_fin;
			res_q.brightness <= maxc_s[QH];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(res_q.hue) < 32'(FULL)))
		else $error("hue reached a full circle");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.brightness == '0)
		|-> (res_q.saturation == '0 && res_q.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s[QH]))
		else $error("divider pipeline moved while stalled");

endmodule

/* rtl/rgb_to_hsv.sv */
// rgb_to_hsv: converts one 8-bit rgb pixel per item into hue, saturation and value.
// Built from rth_front, rth_fifo and rth_back, using rth_pkg. A new pixel is taken
// every clock when the output side keeps up. QH = clog2(360*2^HUE_FRAC_BITS + 1)
// is the number of hue quotient bits (15 at the default of 6) and sets the depth of
// the divider pipeline, since the hue divider resolves one quotient bit per pipeline
// stage. Hue is in units of 1/2^HUE_FRAC_BITS degree, rounded to nearest; saturation
// is 255*delta/max rounded; gray pixels give hue and saturation of zero. A four-entry
// queue lets the input side keep accepting pixels while the output is stalled, until
// the queue is full.

module rgb_to_hsv #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [rth_pkg::IN_W-1:0]  s_axis_tdata, // red, green, blue
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [rth_pkg::OUT_W-1:0] m_axis_tdata  // hue, saturation, brightness, zero pad
);
	import rth_pkg::*;

	logic        f_valid, f_ready;
	rth_item_t   f_item;
	logic        q_valid, q_ready;
	rth_item_t   q_item;
	rth_result_t res;

	rth_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.item_valid    (f_valid),
		.item_ready    (f_ready),
		.item          (f_item)
	);

	rth_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	rth_back #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = OUT_W'(res);

endmodule

/* bench/testbench.sv */
// testbench for rgb_to_hsv: drives 8-bit rgb pixels over the input stream and checks
// hue, saturation and value against a predictor function, queued per pixel by a small scoreboard class
// depends on rth_pkg and rgb_to_hsv from the rtl folder

module testbench;
	import rth_pkg::*;

	localparam int HUE_FRAC  = 6;
	localparam int RAND_ITEMS = 1700;
	localparam int HOLD_LEN  = 300;
	localparam int QUIET_MAX = 5000;
	localparam int TAIL_LEN  = 40;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;  // red, green, blue
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;  // hue, saturation, brightness, zero pad

	int sender_idle;
	int stall_pct;
	int hold_asked;
	int hold_seen;
	int hold_left;
	int quiet;

	rgb_to_hsv #(.HUE_FRAC_BITS(HUE_FRAC)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic rth_result_t predict_hsv(input logic [CH_W-1:0] r, g, b);
		longint unsigned sixth, rr, gg, bb, mx, mn, d, num, hue, sat;
		rth_result_t res;
		sixth = longint'(60) << HUE_FRAC;
		rr = r;
		gg = g;
		bb = b;
		mx = rr;
		mn = rr;
		if (gg > mx) mx = gg;
		if (bb > mx) mx = bb;
		if (gg < mn) mn = gg;
		if (bb < mn) mn = bb;
		d = mx - mn;
		hue = 0;
		sat = 0;
		if (d != 0) begin
			// blue wins ties over green, green over red
			if (mx == bb)
				num = sixth * rr + 4 * sixth * d - sixth * gg;
			else if (mx == gg)
				num = sixth * bb + 2 * sixth * d - sixth * rr;
			else if (gg >= bb)
				num = sixth * (gg - bb);
			else
				num = 6 * sixth * d - sixth * (bb - gg);
			hue = (2 * num + d) / (2 * d);
			if (hue >= 6 * sixth) hue = 0;
			sat = (2 * 255 * d + mx) / (2 * mx);
		end
		res.hue        = hue[HUE_W-1:0];
		res.saturation = sat[SAT_W-1:0];
		res.brightness = mx[CH_W-1:0];
		return res;
	endfunction

	class hsv_scoreboard;
		rth_result_t hsv_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_pixel(input logic [IN_W-1:0] data);
			hsv_q = {hsv_q, predict_hsv(data[7:0], data[15:8], data[23:16])};
		endfunction

		function void check_result(input logic [OUT_W-1:0] data);
			rth_result_t got;
			rth_result_t want;
			got = data[HUE_W+SAT_W+CH_W-1:0];
			if (hsv_q.size() == 0) begin
				$error("result %h with no pixel pending", data);
				errors++;
				return;
			end
			want = hsv_q.pop_front();
			if (got.hue !== want.hue) begin
				$error("hue: expected %0d, got %0d", want.hue, got.hue);
				errors++;
			end
			if (got.saturation !== want.saturation) begin
				$error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
				errors++;
			end
			if (got.brightness !== want.brightness) begin
				$error("brightness: expected %0d, got %0d", want.brightness, got.brightness);
				errors++;
			end
		endfunction
	endclass

	hsv_scoreboard sb;

	always #1 clk = ~clk;

	// output side: check results, stall at random, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// returns at the edge where the item is taken
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		while ($urandom_range(99) < sender_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_pixel(s_axis_tdata);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.hsv_q.size() != 0);
	endtask

	function automatic logic [CH_W-1:0] near(input int base);
		int v;
		v = base + int'($urandom_range(4)) - 2;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[CH_W-1:0];
	endfunction

	task automatic send_random_pixel();
		int kind;
		int base;
		logic [CH_W-1:0] hi, lo;
		kind = $urandom_range(9);
		if (kind < 6) begin
			send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			           CH_W'($urandom_range(255)));
		end else if (kind < 8) begin
			// near gray, small delta
			base = $urandom_range(255);
			send_pixel(near(base), near(base), near(base));
		end else begin
			// two channels tied
			hi = CH_W'($urandom_range(255));
			lo = CH_W'($urandom_range(255));
			case ($urandom_range(2))
				0: send_pixel(hi, hi, lo);
				1: send_pixel(lo, hi, hi);
				default: send_pixel(hi, lo, hi);
			endcase
		end
	endtask

	logic [IN_W-1:0] corner_list [23] = '{
		{8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
		{8'd255, 8'd0, 8'd0}, {8'd0, 8'd255, 8'd0}, {8'd0, 8'd0, 8'd255},
		{8'd255, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd255},
		{8'd1, 8'd0, 8'd0}, {8'd0, 8'd1, 8'd0}, {8'd0, 8'd0, 8'd1},
		{8'd255, 8'd0, 8'd1}, {8'd255, 8'd1, 8'd0}, {8'd255, 8'd254, 8'd254},
		{8'd254, 8'd255, 8'd255}, {8'd1, 8'd1, 8'd0}, {8'd0, 8'd1, 8'd1},
		{8'd200, 8'd100, 8'd50}, {8'd50, 8'd200, 8'd100}, {8'd100, 8'd50, 8'd200},
		{8'd255, 8'd128, 8'd0}, {8'd17, 8'd3, 8'd254}
	};

	int idle_mode [4] = '{0, 77, 0, 29};
	int stall_mode [4] = '{0, 0, 77, 29};

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		sender_idle   = 0;
		stall_pct     = 0;
		hold_asked    = 0;
		hold_seen     = 0;
		hold_left     = 0;
		quiet         = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner pixels: field extremes, ties, gray, wraparound edge
		foreach (corner_list[i])
			send_pixel(corner_list[i][23:16], corner_list[i][15:8], corner_list[i][7:0]);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle = idle_mode[ph];
			stall_pct   = stall_mode[ph];
			if (ph == 0) hold_asked++;
			for (int n = 0; n < RAND_ITEMS / 4; n++)
				send_random_pixel();
			drain_results();
		end

		repeat (TAIL_LEN) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
